// ===== design/tsc_pkg.sv =====
// Shared types and codes for the trade side classifier.
`default_nettype none

package tsc_pkg;

	// Default width of stored and compared prices.
	localparam int PRICE_WIDTH_DEF = 32;

	typedef logic [1:0] tick_kind_t;
	typedef logic [1:0] aggr_t;
	typedef logic [1:0] side_t;

	// Tick kinds.
	localparam tick_kind_t KIND_TRADE = 2'd0;
	localparam tick_kind_t KIND_BID   = 2'd1;
	localparam tick_kind_t KIND_ASK   = 2'd2;
	localparam tick_kind_t KIND_OTHER = 2'd3;

	// Exchange aggressor codes.
	localparam aggr_t AGGR_NONE   = 2'd0;
	localparam aggr_t AGGR_BUYER  = 2'd1;
	localparam aggr_t AGGR_SELLER = 2'd2;

	// Trade side codes.
	localparam side_t SIDE_UNKNOWN = 2'd0;
	localparam side_t SIDE_BID     = 2'd1;
	localparam side_t SIDE_ASK     = 2'd2;
	localparam side_t SIDE_INVALID = 2'd3;

endpackage

`default_nettype wire

// ===== design/trade_side_classifier.sv =====
// Top level of the trade side classifier: request register, classify logic, result register.
//
// Usage:
//   Requests are market ticks (req_type, price, aggressor) on a valid/ready
//   channel. Every request yields exactly one result (side) on the rsp
//   channel, in request order. Bid and ask quotes update the held quotes,
//   other ticks change nothing; both answer side unknown. A trade is
//   classified by the aggressor code, then the quote rule against the
//   midpoint, then the tick rule against the last trade price.
//   A request passes through the request register, then the classify logic
//   writes the result register. One request is taken every cycle while the
//   receiver does not stall; the limit is the single pass through the
//   compare logic that reads and updates the held quotes and last trade.
//   Reset clears the held quotes, last trade price and last side to zero
//   and empties both registers. While the receiver stalls, the result
//   holds and one more request may wait in the request register; req_ready
//   then drops until the result is taken.
`default_nettype none

module trade_side_classifier #(
	parameter int PRICE_WIDTH = tsc_pkg::PRICE_WIDTH_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        req_valid,
	output logic                       req_ready,
	input  wire tsc_pkg::tick_kind_t   req_type,
	input  wire  [PRICE_WIDTH-1:0]     price,
	input  wire tsc_pkg::aggr_t        aggressor,
	output logic                       rsp_valid,
	input  wire                        rsp_ready,
	output tsc_pkg::side_t             side
);
	import tsc_pkg::*;

	// Request register.
	logic                   valid_s1;
	tick_kind_t             kind_s1;
	logic [PRICE_WIDTH-1:0] price_s1;
	aggr_t                  aggr_s1;

	// Held market state.
	logic [PRICE_WIDTH-1:0] bid_q;
	logic [PRICE_WIDTH-1:0] ask_q;
	logic [PRICE_WIDTH-1:0] last_price_q;
	side_t                  last_side_q;

	// Result register.
	logic  rsp_valid_q;
	side_t side_q;

	logic  advance;
	side_t trade_side;
	side_t result_side;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = rsp_valid_q;
	assign side      = side_q;

	// Classify a trade: aggressor, then quote rule, then tick rule.
	always_comb begin
		logic [PRICE_WIDTH:0] twice;
		logic [PRICE_WIDTH:0] quote_sum;
		side_t                quote_side;
		twice      = {price_s1, 1'b0};
		quote_sum  = {1'b0, bid_q} + {1'b0, ask_q};
		quote_side = SIDE_UNKNOWN;
		if (bid_q != '0 && ask_q != '0) begin
			if (twice > quote_sum) begin
				quote_side = SIDE_ASK;
			end else if (twice < quote_sum) begin
				quote_side = SIDE_BID;
			end
		end
		priority if (aggr_s1 == AGGR_BUYER) begin
			trade_side = SIDE_ASK;
		end else if (aggr_s1 == AGGR_SELLER) begin
			trade_side = SIDE_BID;
		end else if (quote_side != SIDE_UNKNOWN) begin
			trade_side = quote_side;
		end else if (last_price_q == '0) begin
			trade_side = SIDE_UNKNOWN;
		end else if (price_s1 > last_price_q) begin
			trade_side = SIDE_ASK;
		end else if (price_s1 < last_price_q) begin
			trade_side = SIDE_BID;
		end else begin
			trade_side = last_side_q;
		end
	end

	assign result_side = (kind_s1 == KIND_TRADE) ? trade_side : SIDE_UNKNOWN;

	// Request register load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			kind_s1  <= req_type;
			price_s1 <= price;
			aggr_s1  <= aggressor;
		end
	end

	// Held state update as a request moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bid_q        <= '0;
			ask_q        <= '0;
			last_price_q <= '0;
			last_side_q  <= SIDE_UNKNOWN;
		end else if (advance) begin
			unique case (kind_s1)
				KIND_TRADE: begin
					last_price_q <= price_s1;
					last_side_q  <= trade_side;
				end
				KIND_BID:   bid_q <= price_s1;
				KIND_ASK:   ask_q <= price_s1;
				KIND_OTHER: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			side_q <= result_side;
		end
	end

endmodule

`default_nettype wire

// ===== design/tsc_checker.sv =====
// Port-level checks for the trade side classifier, bound to its top level.
`default_nettype none

module tsc_checker #(
	parameter int PRICE_WIDTH = tsc_pkg::PRICE_WIDTH_DEF
) (
	input wire                       clk,
	input wire                       arst_n,
	input wire                       req_valid,
	input wire                       req_ready,
	input wire tsc_pkg::tick_kind_t  req_type,
	input wire [PRICE_WIDTH-1:0]     price,
	input wire tsc_pkg::aggr_t       aggressor,
	input wire                       rsp_valid,
	input wire                       rsp_ready,
	input wire tsc_pkg::side_t       side
);
	import tsc_pkg::*;

	// A waiting request keeps its payload until it is taken.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req_type) && $stable(price)
			&& $stable(aggressor))
		else $error("request changed while waiting");

	// A stalled result keeps its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(side))
		else $error("result changed while stalled");

	// The side code is never the unused value.
	a_side_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> side != SIDE_INVALID)
		else $error("result carries an unused side code");

	// With no result waiting, the request register can always drain.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request stalled with an empty result register");

	// A fresh result traces back to a taken request, through the request register.
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("result appeared without a request");

endmodule

bind trade_side_classifier tsc_checker #(.PRICE_WIDTH(PRICE_WIDTH)) u_tsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req_type  (req_type),
	.price     (price),
	.aggressor (aggressor),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.side      (side)
);

`default_nettype wire

// ===== tb/trade_side_classifier_test.sv =====
// Self-checking testbench for the trade side classifier, with a side predictor and random ticks.
`timescale 1ns / 100ps

module trade_side_classifier_test;
	import tsc_pkg::*;

	localparam int PW = PRICE_WIDTH_DEF;
	typedef logic [PW-1:0] price_t;
	localparam price_t PRICE_MAX = '1;
	// Unused aggressor code; the block must treat it like no aggressor.
	localparam aggr_t AGGR_RESERVED = 2'd3;
	localparam int RANDOM_TICKS = 1380;
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_OFF_CYCLES = 80;

	// Predicts the side of every request and checks results in order.
	class trade_side_book;
		price_t bid_q;
		price_t ask_q;
		price_t last_price;
		side_t last_side;
		side_t expected_sides[$];
		int errors;
		int checked;

		function new();
			bid_q = '0;
			ask_q = '0;
			last_price = '0;
			last_side = SIDE_UNKNOWN;
			errors = 0;
			checked = 0;
		endfunction

		// Works out the side of an accepted request and updates the held state.
		function void note_tick(tick_kind_t kind, price_t p, aggr_t aggr);
			side_t s;
			logic [PW:0] twice;
			logic [PW:0] sum;
			s = SIDE_UNKNOWN;
			case (kind)
				KIND_TRADE: begin
					if (aggr == AGGR_BUYER) begin
						s = SIDE_ASK;
					end else if (aggr == AGGR_SELLER) begin
						s = SIDE_BID;
					end else begin
						// Quote rule against the midpoint, only with both quotes held.
						if (bid_q != '0 && ask_q != '0) begin
							twice = {p, 1'b0};
							sum = {1'b0, bid_q} + {1'b0, ask_q};
							if (twice > sum)
								s = SIDE_ASK;
							else if (twice < sum)
								s = SIDE_BID;
						end
						// Tick rule; a zero tick repeats the last side.
						if (s == SIDE_UNKNOWN && last_price != '0) begin
							if (p > last_price)
								s = SIDE_ASK;
							else if (p < last_price)
								s = SIDE_BID;
							else
								s = last_side;
						end
					end
					last_price = p;
					last_side = s;
				end
				KIND_BID: bid_q = p;
				KIND_ASK: ask_q = p;
				default: ;
			endcase
			expected_sides.push_back(s);
		endfunction

		function void check_side(side_t got);
			side_t want;
			if (expected_sides.size() == 0) begin
				$error("side: result with no request pending, actual %0d", got);
				errors++;
				return;
			end
			want = expected_sides.pop_front();
			checked++;
			if (got !== want) begin
				$error("side mismatch: expected %0d, actual %0d", want, got);
				errors++;
			end
		endfunction

		function int pending();
			return expected_sides.size();
		endfunction
	endclass

	typedef struct {
		tick_kind_t kind;
		price_t p;
		aggr_t aggr;
	} tick_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	tick_kind_t req_type;
	price_t price;
	aggr_t aggressor;
	logic rsp_valid;
	logic rsp_ready;
	side_t side;

	trade_side_book sb;
	price_t mid_base;
	bit held_off;

	trade_side_classifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_type(req_type),
		.price(price),
		.aggressor(aggressor),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.side(side)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#1000000;
		$display("trade_side_classifier_test NOT OK");
		$finish;
	end

	// Offers one request and waits until the block takes it.
	task automatic send_tick(input tick_kind_t kind, input price_t p, input aggr_t aggr);
		@(negedge clk);
		req_valid = 1'b1;
		req_type = kind;
		price = p;
		aggressor = aggr;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sb.note_tick(kind, p, aggr);
	endtask

	task automatic idle_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			req_valid = 1'b0;
		end
	endtask

	// Mostly quotes and trades close to a moving base price, with some noise.
	function automatic tick_t random_tick();
		tick_t t;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			t.kind = KIND_TRADE;
		else if (roll < 70)
			t.kind = KIND_BID;
		else if (roll < 90)
			t.kind = KIND_ASK;
		else
			t.kind = KIND_OTHER;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			t.p = mid_base + price_t'($urandom_range(0, 16)) - price_t'(8);
		else if (roll < 86)
			t.p = '0;
		else if (roll < 95)
			t.p = price_t'($urandom);
		else
			t.p = PRICE_MAX - price_t'($urandom_range(0, 6));
		roll = $urandom_range(0, 99);
		if (roll < 70)
			t.aggr = AGGR_NONE;
		else if (roll < 82)
			t.aggr = AGGR_BUYER;
		else if (roll < 94)
			t.aggr = AGGR_SELLER;
		else
			t.aggr = AGGR_RESERVED;
		return t;
	endfunction

	// Request side: reset, directed ticks, then random bursts.
	initial begin
		int burst_left;
		int unsigned roll;
		tick_t t;
		sb = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_type = KIND_OTHER;
		price = '0;
		aggressor = AGGR_NONE;
		mid_base = price_t'(1000);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// No quotes and no earlier trade, then the tick rule and a zero price trade.
		send_tick(KIND_TRADE, 100, AGGR_NONE);
		send_tick(KIND_TRADE, 0, AGGR_NONE);
		send_tick(KIND_TRADE, 50, AGGR_NONE);
		send_tick(KIND_TRADE, 60, AGGR_NONE);
		send_tick(KIND_TRADE, 60, AGGR_NONE);
		// Reported aggressors, and the unused code acting as none.
		send_tick(KIND_TRADE, 55, AGGR_BUYER);
		send_tick(KIND_TRADE, 70, AGGR_SELLER);
		send_tick(KIND_TRADE, 70, AGGR_RESERVED);
		// Only one quote held, so the quote rule stays off.
		send_tick(KIND_BID, 100, AGGR_NONE);
		send_tick(KIND_TRADE, 90, AGGR_NONE);
		// Both quotes held: above, below and at the midpoint.
		send_tick(KIND_ASK, 110, AGGR_NONE);
		send_tick(KIND_TRADE, 106, AGGR_NONE);
		send_tick(KIND_TRADE, 104, AGGR_NONE);
		send_tick(KIND_TRADE, 105, AGGR_NONE);
		send_tick(KIND_OTHER, PRICE_MAX, AGGR_RESERVED);
		// Quotes at full scale, where the sum needs the extra bit.
		send_tick(KIND_BID, PRICE_MAX, AGGR_BUYER);
		send_tick(KIND_ASK, PRICE_MAX, AGGR_SELLER);
		send_tick(KIND_TRADE, PRICE_MAX, AGGR_NONE);
		send_tick(KIND_TRADE, PRICE_MAX - 1, AGGR_NONE);
		send_tick(KIND_TRADE, 0, AGGR_NONE);
		// Clearing quotes turns the quote rule off again.
		send_tick(KIND_BID, 0, AGGR_NONE);
		send_tick(KIND_TRADE, 5, AGGR_NONE);
		send_tick(KIND_ASK, 0, AGGR_NONE);
		send_tick(KIND_OTHER, 0, AGGR_NONE);

		burst_left = 0;
		for (int n = 0; n < RANDOM_TICKS; n++) begin
			// Move the base price now and then, sometimes next to full scale.
			if (n % 100 == 0) begin
				roll = $urandom_range(0, 2);
				if (roll == 0)
					mid_base = price_t'($urandom_range(16, 2000));
				else if (roll == 1)
					mid_base = price_t'($urandom);
				else
					mid_base = PRICE_MAX - price_t'($urandom_range(8, 40));
			end
			if (burst_left == 0) begin
				idle_sender($urandom_range(1, 6));
				burst_left = ($urandom_range(0, 99) < 20) ? 100 : $urandom_range(1, 30);
			end
			t = random_tick();
			send_tick(t.kind, t.p, t.aggr);
			burst_left--;
		end
		@(negedge clk);
		req_valid = 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("trade_side_classifier_test OK");
		else
			$display("trade_side_classifier_test NOT OK");
		$finish;
	end

	// Result side: stall patterns that change from segment to segment, plus one long hold-off.
	initial begin
		int seg_len;
		int unsigned mode;
		rsp_ready = 1'b0;
		held_off = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held_off && sb.checked >= 300) begin
				held_off = 1'b1;
				repeat (HOLD_OFF_CYCLES) begin
					@(negedge clk);
					rsp_ready = 1'b0;
				end
			end else begin
				mode = $urandom_range(0, 3);
				seg_len = $urandom_range(5, 40);
				for (int c = 0; c < seg_len; c++) begin
					@(negedge clk);
					case (mode)
						0: rsp_ready = 1'b1;
						1: rsp_ready = c[0];
						2: rsp_ready = 1'($urandom_range(0, 1));
						default: rsp_ready = ($urandom_range(0, 4) == 0);
					endcase
				end
			end
		end
	end

	// Every result taken is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_side(side);
	end

endmodule
